/* design/pngu_pkg.sv */
// Shared constants, types and helpers for the PNG scanline unfilter core.
package pngu_pkg;

	localparam int MAX_WIDTH       = 1024;
	localparam int ROW_STORE_BYTES = 4096;
	localparam int PALETTE_DEPTH   = 256;

	localparam int COL_W      = $clog2(ROW_STORE_BYTES);
	localparam int PAL_AW     = $clog2(PALETTE_DEPTH);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 2'd3;

	// color modes
	localparam logic [1:0] MODE_GRAY    = 2'd0;
	localparam logic [1:0] MODE_RGB     = 2'd1;
	localparam logic [1:0] MODE_INDEXED = 2'd2;
	localparam logic [1:0] MODE_RGBA    = 2'd3;

	// scanline filter codes
	localparam logic [7:0] FILT_SUB   = 8'd1;
	localparam logic [7:0] FILT_UP    = 8'd2;
	localparam logic [7:0] FILT_AVG   = 8'd3;
	localparam logic [7:0] FILT_PAETH = 8'd4;

	// what an accepted item does
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_FILTER = 2'd1;
	localparam logic [1:0] KIND_PAL    = 2'd2;

	typedef struct packed {
		logic [10:0] image_width;
		logic [15:0] image_height;
		logic [1:0]  color_mode;
		logic [8:0]  palette_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       value;
		logic [7:0]       pal_index;
		logic [23:0]      pal_rgb;
		logic [7:0]       filt;
		logic             first_row;
		logic [1:0]       bip;
		logic             emit;
		logic             row_end;
		logic             image_end;
		logic [COL_W-1:0] col;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       row_end;
		logic       image_end;
	} pix_t;

	function automatic logic [2:0] bpp_of(input logic [1:0] mode);
		logic [2:0] bpp;
		unique case (mode)
			MODE_RGB:  bpp = 3'd3;
			MODE_RGBA: bpp = 3'd4;
			MODE_GRAY, MODE_INDEXED: bpp = 3'd1;
		endcase
		return bpp;
	endfunction

endpackage

/* design/pngu_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module pngu_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

/* design/pngu_ctrl.sv */
// Row sequencer: filter byte, column, pixel byte and row counters, advanced by each accepted scanline byte.
module pngu_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pngu_pkg::cfg_t            cfg,
	input  logic                      load,
	input  logic                      cmd,
	input  logic [7:0]                data_byte,
	input  logic [7:0]                pal_index,
	input  logic [23:0]               pal_rgb,
	output pngu_pkg::item_t           item,
	output logic [pngu_pkg::COL_W-1:0] rd_addr
);
	import pngu_pkg::*;

	localparam int LEN_W = 11 + 2;
	localparam int LIM1  = (MAX_WIDTH < ROW_STORE_BYTES)     ? MAX_WIDTH : ROW_STORE_BYTES;
	localparam int LIM3  = (MAX_WIDTH < ROW_STORE_BYTES / 3) ? MAX_WIDTH : ROW_STORE_BYTES / 3;
	localparam int LIM4  = (MAX_WIDTH < ROW_STORE_BYTES / 4) ? MAX_WIDTH : ROW_STORE_BYTES / 4;

	logic             awaiting_q;
	logic [COL_W-1:0] col_q;
	logic [1:0]       bip_q;
	logic [15:0]      row_q;
	logic [7:0]       filt_q;

	logic [2:0]       bpp;
	logic [10:0]      w0;
	logic [10:0]      w;
	int               lim;
	logic [LEN_W-1:0] len;
	logic [COL_W-1:0] col_next;
	logic             row_done;
	logic             emit;
	logic [15:0]      height;
	logic             last;

	always_comb begin
		bpp = bpp_of(cfg.color_mode);
		w0  = (cfg.image_width == '0) ? 11'd1 : cfg.image_width;
		case (bpp)
			3'd3:    lim = LIM3;
			3'd4:    lim = LIM4;
			default: lim = LIM1;
		endcase
		w = (int'(w0) > lim) ? 11'(lim) : w0;
		case (bpp)
			3'd3:    len = LEN_W'(w) + LEN_W'({w, 1'b0});
			3'd4:    len = LEN_W'({w, 2'b00});
			default: len = LEN_W'(w);
		endcase
		col_next = col_q + COL_W'(1);
		row_done = LEN_W'(col_next) >= len;
		emit     = (3'(bip_q) + 3'd1) >= bpp;
		height   = (cfg.image_height == '0) ? 16'd1 : cfg.image_height;
		last     = ({1'b0, row_q} + 17'd1) >= {1'b0, height};
	end

	always_comb begin
		if (cmd) begin
			item.kind = KIND_PAL;
		end else if (awaiting_q) begin
			item.kind = KIND_FILTER;
		end else begin
			item.kind = KIND_DATA;
		end
		item.value     = data_byte;
		item.pal_index = pal_index;
		item.pal_rgb   = pal_rgb;
		item.filt      = filt_q;
		item.first_row = (row_q == '0);
		item.bip       = bip_q;
		item.emit      = emit;
		item.row_end   = row_done;
		item.image_end = row_done && last;
		item.col       = col_q;
	end

	assign rd_addr = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			col_q      <= '0;
			bip_q      <= '0;
			row_q      <= '0;
			filt_q     <= '0;
		end else if (load && !cmd) begin
			if (awaiting_q) begin
				filt_q     <= data_byte;
				awaiting_q <= 1'b0;
				col_q      <= '0;
				bip_q      <= '0;
			end else if (row_done) begin
				row_q      <= last ? 16'd0 : row_q + 16'd1;
				awaiting_q <= 1'b1;
				col_q      <= '0;
				bip_q      <= '0;
			end else begin
				col_q <= col_next;
				bip_q <= emit ? 2'd0 : bip_q + 2'd1;
			end
		end
	end

endmodule

/* design/pngu_recon.sv */
// Reconstruction stage: upper row RAM, filter reversal, pixel gather and palette lookup.
module pngu_recon (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pngu_pkg::cfg_t             cfg,
	input  logic                       load,
	input  pngu_pkg::item_t            load_item,
	input  logic [pngu_pkg::COL_W-1:0] rd_addr,
	input  logic                       go,
	output logic                       has_result,
	output pngu_pkg::pix_t             res
);
	import pngu_pkg::*;

	item_t       item_s1;
	logic [31:0] left_q;
	logic [31:0] ul_q;
	logic [23:0] gather_q;

	logic [23:0] rgb_s2;
	logic        use_pal_s2;
	logic        pal_ok_s2;
	logic        row_end_s2;
	logic        image_end_s2;

	logic [7:0]  b_raw;
	logic [23:0] pal_rd;

	logic [7:0]  a;
	logic [7:0]  b;
	logic [7:0]  c;
	logic [8:0]  avg_sum;
	logic signed [9:0] pa_d, pb_d, pc_d;
	logic [9:0]  pa, pb, pc;
	logic [7:0]  paeth;
	logic [7:0]  pred;
	logic [7:0]  v;
	logic        wide;
	logic        indexed;
	logic [23:0] gather_n;
	logic [23:0] rgb_n;
	logic [8:0]  count_sat;
	logic        pal_ok;
	logic        is_data;
	logic        pal_we;

	always_comb begin
		unique case (cfg.color_mode)
			MODE_RGB: begin
				a = left_q[23:16];
				c = ul_q[23:16];
			end
			MODE_RGBA: begin
				a = left_q[31:24];
				c = ul_q[31:24];
			end
			MODE_GRAY, MODE_INDEXED: begin
				a = left_q[7:0];
				c = ul_q[7:0];
			end
		endcase
		b = item_s1.first_row ? 8'd0 : b_raw;

		avg_sum = {1'b0, a} + {1'b0, b};
		// p - a = b - c, p - b = a - c, p - c = a + b - 2c
		pa_d = $signed({2'b00, b}) - $signed({2'b00, c});
		pb_d = $signed({2'b00, a}) - $signed({2'b00, c});
		pc_d = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
		pa   = pa_d[9] ? 10'(-pa_d) : 10'(pa_d);
		pb   = pb_d[9] ? 10'(-pb_d) : 10'(pb_d);
		pc   = pc_d[9] ? 10'(-pc_d) : 10'(pc_d);
		if (pa <= pb && pa <= pc) begin
			paeth = a;
		end else if (pb <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end

		case (item_s1.filt)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth;
			default:    pred = 8'd0;
		endcase
		v = item_s1.value + pred;

		wide    = (cfg.color_mode == MODE_RGB) || (cfg.color_mode == MODE_RGBA);
		indexed = (cfg.color_mode == MODE_INDEXED);

		rgb_n = {v, v, v};
		if (wide) begin
			rgb_n = gather_q | ((item_s1.bip == 2'd2) ? {16'd0, v} : 24'd0);
		end

		gather_n = gather_q;
		if (item_s1.emit) begin
			gather_n = '0;
		end else begin
			case (item_s1.bip)
				2'd0:    gather_n = gather_q | {v, 16'd0};
				2'd1:    gather_n = gather_q | {8'd0, v, 8'd0};
				2'd2:    gather_n = gather_q | {16'd0, v};
				default: gather_n = gather_q;
			endcase
		end
		if (item_s1.row_end) begin
			gather_n = '0;
		end

		count_sat = (int'(cfg.palette_count) > PALETTE_DEPTH) ?
			9'(PALETTE_DEPTH) : cfg.palette_count;
		pal_ok = {1'b0, v} < count_sat;

		is_data    = (item_s1.kind == KIND_DATA);
		has_result = is_data && item_s1.emit;
		pal_we     = go && (item_s1.kind == KIND_PAL) &&
			(int'(item_s1.pal_index) < PALETTE_DEPTH);
	end

	pngu_ram #(
		.DEPTH(ROW_STORE_BYTES),
		.WIDTH(8)
	) u_upper_row (
		.clk  (clk),
		.we   (go && is_data),
		.waddr(item_s1.col),
		.wdata(v),
		.re   (load),
		.raddr(rd_addr),
		.rdata(b_raw)
	);

	pngu_ram #(
		.DEPTH(PALETTE_DEPTH),
		.WIDTH(24)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(item_s1.pal_index[PAL_AW-1:0]),
		.wdata(item_s1.pal_rgb),
		.re   (go && has_result && indexed),
		.raddr(v[PAL_AW-1:0]),
		.rdata(pal_rd)
	);

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= load_item;
		end
		if (go && has_result) begin
			rgb_s2       <= rgb_n;
			use_pal_s2   <= indexed;
			pal_ok_s2    <= pal_ok;
			row_end_s2   <= item_s1.row_end;
			image_end_s2 <= item_s1.image_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			ul_q     <= '0;
			gather_q <= '0;
		end else if (go) begin
			case (item_s1.kind)
				KIND_FILTER: begin
					left_q   <= '0;
					ul_q     <= '0;
					gather_q <= '0;
				end
				KIND_DATA: begin
					left_q   <= {left_q[23:0], v};
					ul_q     <= {ul_q[23:0], b};
					gather_q <= gather_n;
				end
				default: begin
					// palette writes leave the row state alone
				end
			endcase
		end
	end

	always_comb begin
		if (use_pal_s2) begin
			{res.red, res.green, res.blue} = pal_ok_s2 ? pal_rd : 24'd0;
		end else begin
			{res.red, res.green, res.blue} = rgb_s2;
		end
		res.row_end   = row_end_s2;
		res.image_end = image_end_s2;
	end

endmodule

/* design/png_scanline_unfilter_to_rgb_core.sv */
// Top level of the PNG scanline unfilter core: config registers, stage valids, output register.
//
//  channel   | role   | transfer                     | payload
//  s_axis    | input  | s_axis_tvalid & s_axis_tready | scanline byte or palette entry
//  m_axis    | output | m_axis_tvalid & m_axis_tready | RGB pixel, row and image end
//  cfg       | input  | cfg_we                        | register index and value
//
// One item per cycle is accepted while s_axis_tready is high; m_axis_tvalid rises once the
// transfer of a pixel's last byte has passed these registers: stage 1 and the upper row RAM
// read load at accept, stage 2 and the palette RAM read load as the byte leaves stage 1, then
// the output register loads. Filter bytes and palette writes give no pixel.
// Reset clears the counters, histories and valids; the row and palette RAMs are not cleared.
// s_axis_tready falls only while stage 1 holds a pixel that stage 2 cannot take.
module png_scanline_unfilter_to_rgb_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pngu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pngu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// data_byte, palette_index, palette_red, palette_green, palette_blue
	input  logic [39:0]                     s_axis_tdata,
	// cmd
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// red, green, blue
	output logic [23:0]                     m_axis_tdata,
	// row_end
	output logic                            m_axis_tlast,
	// image_end
	output logic                            m_axis_tuser
);
	import pngu_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	pix_t  res;

	logic [COL_W-1:0] rd_addr;
	logic s1_v_q, s2_v_q, out_v_q;
	logic out_free, s2_free, s2_go, s1_go, has_result, load;

	assign out_free      = !out_v_q || m_axis_tready;
	assign s2_go         = s2_v_q && out_free;
	assign s2_free       = !s2_v_q || out_free;
	assign s1_go         = s1_v_q && (!has_result || s2_free);
	assign s_axis_tready = !s1_v_q || s1_go;
	assign load          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= 11'd1;
			cfg_q.image_height  <= 16'd1;
			cfg_q.color_mode    <= MODE_RGB;
			cfg_q.palette_count <= 9'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[10:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[15:0];
				REG_COLOR_MODE:    cfg_q.color_mode    <= cfg_data[1:0];
				REG_PALETTE_COUNT: cfg_q.palette_count <= cfg_data[8:0];
			endcase
		end
	end

	pngu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.load     (load),
		.cmd      (s_axis_tuser),
		.data_byte(s_axis_tdata[7:0]),
		.pal_index(s_axis_tdata[15:8]),
		.pal_rgb  ({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
		.item     (item),
		.rd_addr  (rd_addr)
	);

	pngu_recon u_recon (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.load      (load),
		.load_item (item),
		.rd_addr   (rd_addr),
		.go        (s1_go),
		.has_result(has_result),
		.res       (res)
	);

	// tdata carries red in the low byte; the palette input holds red in s_axis_tdata[23:16]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				s1_v_q <= 1'b1;
			end else if (s1_go) begin
				s1_v_q <= 1'b0;
			end
			if (s1_go && has_result) begin
				s2_v_q <= 1'b1;
			end else if (s2_go) begin
				s2_v_q <= 1'b0;
			end
			if (s2_go) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			m_axis_tdata <= {res.blue, res.green, res.red};
			m_axis_tlast <= res.row_end;
			m_axis_tuser <= res.image_end;
		end
	end

	assign m_axis_tvalid = out_v_q;

	a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("image end without row end");

	a_ready_when_s1_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_v_q |-> s_axis_tready)
		else $error("input stalled with stage 1 empty");

	a_s2_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q && m_axis_tvalid && !m_axis_tready |=> s2_v_q)
		else $error("stage 2 pixel lost during output stall");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> s1_v_q)
		else $error("accepted item missing from stage 1");

endmodule
